[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the scalar Kalman filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define SKF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/skf_pkg.sv]
// Package with the widths, constants and types of the scalar Kalman filter.
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = GAIN_BITS + 1;
  localparam int DEN_W     = DATA_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 5;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ESTIMATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV      = 2'd3;

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd66;
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd65536;
  localparam logic [DATA_W-1:0] INIT_ESTIMATE_RST = 32'd0;
  localparam logic [DATA_W-1:0] INIT_COV_RST      = 32'd65536;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[hw/rtl/skf_in_if.sv]
// Request channel carrying one measurement sample into the filter.
`default_nettype none

interface skf_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [skf_pkg::DATA_W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

`default_nettype wire

[hw/rtl/skf_out_if.sv]
// Result channel carrying the new estimate and the gain out of the filter.
`default_nettype none

interface skf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [skf_pkg::DATA_W-1:0] estimate;
  logic        [skf_pkg::GAIN_W-1:0] gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

[hw/rtl/skf_div.sv]
// Restoring divider forming the gain (num << 16) / den, one quotient bit per cycle.
`default_nettype none

module skf_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [skf_pkg::DATA_W-1:0]   num,
  input  wire logic [skf_pkg::DEN_W-1:0]    den,
  output      logic [skf_pkg::GAIN_W-1:0]   quot,
  output      skf_pkg::div_stat_t           stat
);

  logic [skf_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [skf_pkg::DEN_W-1:0]  den_r;
  logic [skf_pkg::GAIN_W-1:0] q_r, q_nxt;
  logic [skf_pkg::CNT_W-1:0]  cnt_r;
  logic                       done_r;
  logic                       den_zero_r;
  logic [skf_pkg::DEN_W:0]    trial;
  logic                       ge;

  // The remainder stays below the divisor after the first step, so the
  // first step compares without a shift and the rest shift one bit.
  always_comb begin
    if (cnt_r == skf_pkg::CNT_W'(skf_pkg::GAIN_W)) begin
      trial = {1'b0, rem_r};
    end else begin
      trial = {rem_r, 1'b0};
    end
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? skf_pkg::DEN_W'(trial - {1'b0, den_r}) : trial[skf_pkg::DEN_W-1:0];
    q_nxt   = {q_r[skf_pkg::GAIN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= skf_pkg::CNT_W'(skf_pkg::GAIN_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == skf_pkg::CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r      <= {1'b0, num};
      den_r      <= den;
      den_zero_r <= den == '0;
      q_r        <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quot      = den_zero_r ? '0 : q_r;
  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;

endmodule

`default_nettype wire

[hw/rtl/scalar_kalman_filter_unit.sv]
// Top level of the scalar Kalman filter: sequencer, shared multiplier and state.
//
// One-dimensional Kalman filter in Q16.16 fixed point. Each measurement request
// first grows the covariance by the process noise (saturating at the largest
// 32-bit value), then forms the gain cov / (cov + measurement noise) in Q1.16
// with a restoring divider that yields one quotient bit per cycle. The estimate
// then moves toward the measurement by the gain times the difference, and the
// covariance is scaled by one minus the gain; both products go through one
// shared 33 x 18 signed multiplier on successive cycles. A request holds the
// block from acceptance until it is ready again, and longer while the result
// channel has not taken the previous result. The result sits in an output
// register, so a new request is accepted while a finished result still waits.
// A zero denominator gives a gain of zero. Writing the initial estimate or
// initial covariance register loads that value straight into the filter state;
// configuration must be written only while the block is idle, which the block
// itself does not enforce.
`default_nettype none

`include "assert_macros.svh"

module scalar_kalman_filter_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [skf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [skf_pkg::DATA_W-1:0]     cfg_wdata,
  skf_in_if.sink                              in_chan,
  skf_out_if.source                           out_chan
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_PRED  = 3'd1;
  localparam logic [ST_W-1:0] ST_DSTRT = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV   = 3'd3;
  localparam logic [ST_W-1:0] ST_MULE  = 3'd4;
  localparam logic [ST_W-1:0] ST_MULC  = 3'd5;
  localparam logic [ST_W-1:0] ST_FIN   = 3'd6;

  localparam int DW   = skf_pkg::DATA_W;
  localparam int GW   = skf_pkg::GAIN_W;
  localparam int MB_W = GW + 1;
  localparam int PW   = skf_pkg::DEN_W + MB_W;
  localparam int GB   = skf_pkg::GAIN_BITS;

  logic [ST_W-1:0]                 state_r;
  logic [DW-1:0]                   q_r;
  logic [DW-1:0]                   r_r;
  logic signed [DW-1:0]            est_r;
  logic [DW-1:0]                   cov_r;
  logic signed [DW-1:0]            meas_r;
  logic [DW-1:0]                   cov_pred_r;
  logic signed [skf_pkg::DEN_W-1:0] diff_r;
  logic [GW-1:0]                   gain_r;
  logic signed [PW-1:0]            prod_r;
  logic                            out_valid_r;
  logic signed [DW-1:0]            out_est_r;
  logic [GW-1:0]                   out_gain_r;

  logic [DW:0]                     cov_sum;
  logic [DW-1:0]                   cov_sat;
  logic [skf_pkg::DEN_W-1:0]       den;
  logic                            div_start;
  logic [GW-1:0]                   div_quot;
  skf_pkg::div_stat_t              div_stat;
  logic signed [skf_pkg::DEN_W-1:0] mul_a;
  logic signed [MB_W-1:0]          mul_b;
  logic signed [PW-1:0]            mul_p;
  logic signed [skf_pkg::DEN_W-1:0] est_sum;
  logic                            in_acc;
  logic                            out_load;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  // Prediction: the covariance grows by the process noise, clamped at all ones.
  assign cov_sum = {1'b0, cov_r} + {1'b0, q_r};
  assign cov_sat = cov_sum[DW] ? '1 : cov_sum[DW-1:0];

  // Gain denominator, at most 33 bits wide.
  assign den       = {1'b0, cov_pred_r} + {1'b0, r_r};
  assign div_start = state_r == ST_DSTRT;

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cov_pred_r),
    .den   (den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // The one multiplier serves the estimate correction first and then the
  // covariance update. Both gain operands are non-negative.
  always_comb begin
    if (state_r == ST_MULE) begin
      mul_a = diff_r;
      mul_b = $signed({1'b0, gain_r});
    end else begin
      mul_a = $signed({1'b0, cov_pred_r});
      mul_b = $signed({1'b0, GW'(skf_pkg::GAIN_ONE - gain_r)});
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Dropping the low fraction bits of the two's complement product rounds
  // the correction toward minus infinity. The new estimate lies between the
  // old estimate and the measurement, so its low 32 bits are exact.
  assign est_sum = $signed({est_r[DW-1], est_r}) + prod_r[GB+skf_pkg::DEN_W-1:GB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= skf_pkg::PROCESS_NOISE_RST;
      r_r         <= skf_pkg::MEASURE_NOISE_RST;
      est_r       <= skf_pkg::INIT_ESTIMATE_RST;
      cov_r       <= skf_pkg::INIT_COV_RST;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_idx)
          skf_pkg::REG_PROCESS_NOISE: q_r   <= cfg_wdata;
          skf_pkg::REG_MEASURE_NOISE: r_r   <= cfg_wdata;
          skf_pkg::REG_INIT_ESTIMATE: est_r <= $signed(cfg_wdata);
          skf_pkg::REG_INIT_COV:      cov_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_PRED;
          end
        end
        ST_PRED:  state_r <= ST_DSTRT;
        ST_DSTRT: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_MULE;
          end
        end
        ST_MULE:  state_r <= ST_MULC;
        ST_MULC: begin
          est_r   <= est_sum[DW-1:0];
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // The covariance product is non-negative and below 2^48.
          cov_r <= prod_r[GB+DW-1:GB];
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas_r <= in_chan.measurement;
    end
    if (state_r == ST_PRED) begin
      cov_pred_r <= cov_sat;
      diff_r     <= $signed({meas_r[DW-1], meas_r}) - $signed({est_r[DW-1], est_r});
    end
    if (state_r == ST_DIV && div_stat.done) begin
      gain_r <= div_quot;
    end
    if (state_r == ST_MULE || state_r == ST_MULC) begin
      prod_r <= mul_p;
    end
    if (out_load) begin
      out_est_r  <= est_r;
      out_gain_r <= gain_r;
    end
  end

  assign in_chan.ready  = state_r == ST_IDLE;
  assign out_chan.valid = out_valid_r;
  assign out_chan.estimate = out_est_r;
  assign out_chan.gain  = out_gain_r;

  `SKF_ASSERT(a_gain_range, out_chan.valid, out_chan.gain <= skf_pkg::GAIN_ONE, "gain above one")
  `SKF_ASSERT_NEXT(a_acc_pred, in_acc, state_r == ST_PRED, "accepted request did not start")
  `SKF_ASSERT(a_div_done, div_stat.done, state_r == ST_DIV, "divider finished out of sequence")
  `SKF_ASSERT(a_idle_div, state_r == ST_IDLE, !div_stat.busy, "divider busy while idle")

endmodule

`default_nettype wire
